@@ src/mtt_pkg.sv @@
// Package: shared constants and types for the timer table
package mtt_pkg;

	localparam int MaxTimersDef = 32;

	typedef enum logic [2:0] {
		MODE_START     = 3'd0,
		MODE_STOP_ID   = 3'd1,
		MODE_STOP_OWN  = 3'd2,
		MODE_STOP_OT   = 3'd3,
		MODE_QRY_ID    = 3'd4,
		MODE_QRY_OWN   = 3'd5,
		MODE_QRY_OT    = 3'd6,
		MODE_TICK      = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_SHIFT,
		S_REPLY
	} state_t;

	localparam logic [31:0] StepMax  = 32'hFFFF_FFFF;
	localparam logic [47:0] TotalMax = 48'hFFFF_FFFF_FFFF;

endpackage

@@ src/multi_timer_table.sv @@
// Top level: ordered software timer table with a walking sequencer
// A start goes straight to its reply; stop, query and tick walk the table entry
// by entry, with a read state and an evaluate state for each entry, then reply.
// Each removal shifts the tail one entry per cycle.
// One item at a time: busy stays high until the cycle that drives the last result.
// Reset clears entry count, id counter and control; table memories need none.
// Results are strobed for one cycle by valid; the receiver cannot stall them.
module multi_timer_table #(
	parameter int MAX_TIMERS = mtt_pkg::MaxTimersDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [15:0] owner,
	input  logic [15:0] tag,
	input  logic [31:0] interval,
	input  logic [31:0] timer_id,
	input  logic [31:0] elapsed,
	output logic        valid,
	output logic        result_kind,
	output logic [1:0]  status,
	output logic [31:0] timer_id_out,
	output logic [15:0] owner_out,
	output logic [15:0] tag_out,
	output logic [31:0] step_time,
	output logic [47:0] total_time,
	output logic        running,
	output logic        last
);
	localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CW = $clog2(MAX_TIMERS + 1);
	localparam logic [CW-1:0] CntMax = CW'(MAX_TIMERS);

	// one packed word per entry
	typedef struct packed {
		logic [15:0] own;
		logic [15:0] tg;
		logic [31:0] id;
		logic [31:0] ivl;
		logic signed [33:0] rem;
		logic [31:0] st;
		logic [47:0] tt;
	} entry_t;

	entry_t mem [MAX_TIMERS];

	mtt_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [31:0]   next_id_q;
	logic [CW-1:0] idx_q;     // walk index
	logic [CW-1:0] sh_q;      // shift index
	logic          hit_q;
	logic [2:0]    mode_q;
	logic [15:0]   own_q, tg_q;
	logic [31:0]   id_q, el_q;
	entry_t        rd_q;
	logic [CW-1:0] rd_addr;
	logic          rd_en;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	// shift uses a flag to know read data is live
	logic          sh_live_q;
	logic [AW-1:0] sh_wa_q;

	// result register
	logic        o_valid_q, o_kind_q, o_last_q;
	logic [1:0]  o_status_q;
	logic [31:0] o_id_q, o_st_q;
	logic [15:0] o_own_q, o_tg_q;
	logic [47:0] o_tt_q;

	assign busy = (state_q != mtt_pkg::S_IDLE);

	// memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr[AW-1:0]];
	end

	// tick arithmetic and match compare on the entry read
	logic [32:0]        st_sum;
	logic [48:0]        tt_sum;
	logic [31:0]        st_new;
	logic [47:0]        tt_new;
	logic signed [33:0] rem_sub, rem_add, rem_new;
	logic               fire, match;
	always_comb begin
		st_sum = {1'b0, rd_q.st} + {1'b0, el_q};
		tt_sum = {1'b0, rd_q.tt} + {17'd0, el_q};
		st_new = st_sum[32] ? mtt_pkg::StepMax : st_sum[31:0];
		tt_new = tt_sum[48] ? mtt_pkg::TotalMax : tt_sum[47:0];
		rem_sub = rd_q.rem - $signed({2'b00, el_q});
		rem_add = rem_sub + $signed({2'b00, rd_q.ivl});
		fire = 1'b0;
		rem_new = rd_q.rem;
		if (rd_q.ivl == 32'd0) begin
			fire = 1'b1;
		end else if (rem_sub <= 0) begin
			fire = 1'b1;
			rem_new = (rem_add <= 0) ? $signed({2'b00, rd_q.ivl}) : rem_add;
		end else begin
			rem_new = rem_sub;
		end
		case (mode_q)
			mtt_pkg::MODE_STOP_ID, mtt_pkg::MODE_QRY_ID: match = (rd_q.id == id_q);
			mtt_pkg::MODE_STOP_OWN, mtt_pkg::MODE_QRY_OWN: match = (rd_q.own == own_q);
			default: match = (rd_q.own == own_q) && (rd_q.tg == tg_q);
		endcase
	end

	logic is_stop, all_stop;
	assign is_stop  = (mode_q == mtt_pkg::MODE_STOP_ID) || (mode_q == mtt_pkg::MODE_STOP_OWN)
		|| (mode_q == mtt_pkg::MODE_STOP_OT);
	assign all_stop = (mode_q == mtt_pkg::MODE_STOP_OWN);

	// next state and memory control
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_q;
		case (state_q)
			mtt_pkg::S_IDLE: begin
				if (start) begin
					if (mode == mtt_pkg::MODE_START)
						state_d = mtt_pkg::S_REPLY;
					else
						state_d = mtt_pkg::S_READ;
				end
			end
			mtt_pkg::S_READ: begin
				if (idx_q >= count_q) begin
					state_d = mtt_pkg::S_REPLY;
				end else begin
					rd_en   = 1'b1;
					state_d = mtt_pkg::S_EVAL;
				end
			end
			mtt_pkg::S_EVAL: begin
				if (mode_q == mtt_pkg::MODE_TICK) begin
					wr_en = 1'b1;
					wr_data.st  = fire ? 32'd0 : st_new;
					wr_data.tt  = tt_new;
					wr_data.rem = rem_new;
					state_d = mtt_pkg::S_READ;
				end else if (match && is_stop) begin
					state_d = mtt_pkg::S_SHIFT;
				end else if (match) begin
					state_d = mtt_pkg::S_REPLY;
				end else begin
					state_d = mtt_pkg::S_READ;
				end
			end
			mtt_pkg::S_SHIFT: begin
				// move entry sh+1 down to sh; its read is issued the cycle before its write
				if (sh_q + CW'(1) >= count_q) begin
					state_d = all_stop ? mtt_pkg::S_READ : mtt_pkg::S_REPLY;
				end else begin
					rd_en   = 1'b1;
					rd_addr = sh_q + CW'(1);
					state_d = mtt_pkg::S_SHIFT;
				end
			end
			mtt_pkg::S_REPLY: state_d = mtt_pkg::S_IDLE;
			default: state_d = mtt_pkg::S_IDLE;
		endcase
		if (state_q == mtt_pkg::S_IDLE && start && mode == mtt_pkg::MODE_START
			&& count_q < CntMax) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AW-1:0];
			wr_data = '{own: owner, tg: tag, id: next_id_q + 32'd1, ivl: interval,
				rem: $signed({2'b00, interval}), st: 32'd0, tt: 48'd0};
		end
		// write of shifted entry lands the cycle after its read
		if (sh_live_q) begin
			wr_en   = 1'b1;
			wr_addr = sh_wa_q;
			wr_data = rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sh_live_q <= 1'b0;
		else
			sh_live_q <= (state_q == mtt_pkg::S_SHIFT) && rd_en;
	end

	always_ff @(posedge clk) begin
		sh_wa_q <= sh_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mtt_pkg::S_IDLE;
			count_q   <= '0;
			next_id_q <= '0;
			idx_q     <= '0;
			sh_q      <= '0;
			hit_q     <= 1'b0;
			mode_q    <= mtt_pkg::MODE_START;
			own_q     <= '0;
			tg_q      <= '0;
			id_q      <= '0;
			el_q      <= '0;
			o_valid_q <= 1'b0;
			o_kind_q  <= 1'b0;
			o_last_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			o_valid_q <= 1'b0;
			case (state_q)
				mtt_pkg::S_IDLE: begin
					if (start) begin
						mode_q <= mode;
						own_q  <= owner;
						tg_q   <= tag;
						id_q   <= timer_id;
						el_q   <= elapsed;
						idx_q  <= '0;
						hit_q  <= 1'b0;
						if (mode == mtt_pkg::MODE_START) begin
							if (count_q < CntMax) begin
								next_id_q <= next_id_q + 32'd1;
								count_q   <= count_q + CW'(1);
								hit_q     <= 1'b1;
							end
						end
					end
				end
				mtt_pkg::S_EVAL: begin
					if (mode_q == mtt_pkg::MODE_TICK) begin
						idx_q <= idx_q + CW'(1);
						if (fire) begin
							o_valid_q <= 1'b1;
							o_kind_q  <= 1'b1;
							o_last_q  <= 1'b0;
						end
					end else if (match) begin
						hit_q <= 1'b1;
						sh_q  <= idx_q;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				mtt_pkg::S_SHIFT: begin
					if (sh_q + CW'(1) >= count_q)
						count_q <= count_q - CW'(1);
					else
						sh_q <= sh_q + CW'(1);
				end
				mtt_pkg::S_REPLY: begin
					o_valid_q <= 1'b1;
					o_kind_q  <= 1'b0;
					o_last_q  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == mtt_pkg::S_EVAL && mode_q == mtt_pkg::MODE_TICK) begin
			o_status_q <= mtt_pkg::ST_OK;
			o_id_q     <= rd_q.id;
			o_own_q    <= rd_q.own;
			o_tg_q     <= rd_q.tg;
			o_st_q     <= st_new;
			o_tt_q     <= tt_new;
		end else if (state_q == mtt_pkg::S_REPLY) begin
			o_own_q <= '0;
			o_tg_q  <= '0;
			o_st_q  <= '0;
			o_tt_q  <= '0;
			o_id_q  <= '0;
			if (mode_q == mtt_pkg::MODE_TICK) begin
				o_status_q <= mtt_pkg::ST_OK;
			end else if (mode_q == mtt_pkg::MODE_START) begin
				o_status_q <= hit_q ? mtt_pkg::ST_OK : mtt_pkg::ST_FULL;
				o_id_q     <= hit_q ? next_id_q : 32'd0;
			end else begin
				o_status_q <= hit_q ? mtt_pkg::ST_OK : mtt_pkg::ST_NOTFOUND;
			end
		end
	end

	assign valid        = o_valid_q;
	assign result_kind  = o_kind_q;
	assign status       = o_status_q;
	assign timer_id_out = o_id_q;
	assign owner_out    = o_own_q;
	assign tag_out      = o_tg_q;
	assign step_time    = o_st_q;
	assign total_time   = o_tt_q;
	assign running      = (count_q != '0);
	assign last         = o_last_q;
endmodule

@@ src/mtt_checker.sv @@
// Checker: port-level properties of the timer table, bound to the top level
module mtt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        valid,
	input logic        result_kind,
	input logic [1:0]  status,
	input logic        last
);
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> !busy) else $error("busy after last result");
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && result_kind |-> status == mtt_pkg::ST_OK && !last)
		else $error("bad fire report");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item without busy");
	a_fire_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy) else $error("fire report while idle");
endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .valid(valid),
	.result_kind(result_kind), .status(status), .last(last)
);
